// ===== design/dsci_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the depth sorted command insert core.
// No dependencies; imported by every module of the block.
package dsci_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int HEADER_BYTES = 16;

    localparam int POS_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int NEED_W = 17;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 3;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // One stored list entry.
    typedef struct packed {
        logic [31:0] depth;
        logic [15:0] layer;
        logic [15:0] offset;
        logic [1:0]  kind;
    } entry_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_item;
        logic start_push;
        logic read_issue;
        logic scan_shift;
        logic scan_place;
        logic read_done;
        logic res_none;
        logic do_clear;
        logic load_out;
    } dsci_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic             is_push;
        logic             is_read;
        logic             is_clear;
        logic             push_ok;
        logic             read_ok;
        logic             scan_go;
        logic [CNT_W-1:0] count;
    } dsci_stat_t;

endpackage

// ===== design/dsci_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: item capture, sorted entry memory, buffer accounting, result registers.
// Depends on dsci_pkg; driven by dsci_ctrl commands.
module dsci_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [dsci_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [dsci_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          cfg_wen,
    input  logic [15:0]                   cfg_wdata,
    input  dsci_pkg::dsci_cmd_t           cmd,
    output dsci_pkg::dsci_stat_t          stat,
    output logic [dsci_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [dsci_pkg::M_TUSER_W-1:0] m_tuser
);
    import dsci_pkg::*;

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;
    logic [POS_W-1:0] rd_addr;

    logic [1:0]  cmd_reg;
    logic [11:0] payload_reg;
    logic [1:0]  kind_reg;
    logic [31:0] depth_reg;
    logic [15:0] layer_reg;
    logic [5:0]  rpos_reg;

    logic [15:0]      capacity_reg;
    logic [15:0]      bytes_used_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] pos_reg;

    logic [NEED_W-1:0] need;
    logic [15:0]       offset;
    logic              sorts_first;
    entry_t            new_entry;

    // staged result
    logic        res_acc_reg;
    logic [15:0] res_poff_reg;
    logic [5:0]  res_land_reg;
    logic [1:0]  res_rkind_reg;
    logic [15:0] res_roff_reg;
    logic [31:0] res_rdepth_reg;
    logic [15:0] res_rlayer_reg;
    logic [6:0]  res_total_reg;

    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cmd_reg     <= s_tuser[1:0];
            kind_reg    <= s_tuser[3:2];
            payload_reg <= s_tdata[11:0];
            depth_reg   <= s_tdata[43:12];
            layer_reg   <= s_tdata[59:44];
            rpos_reg    <= s_tdata[65:60];
        end
    end

    assign need   = NEED_W'(bytes_used_reg) + NEED_W'(HEADER_BYTES) + NEED_W'(payload_reg);
    assign offset = 16'(NEED_W'(bytes_used_reg) + NEED_W'(HEADER_BYTES));

    // strict order: depth first, then layer, both signed
    assign sorts_first = ($signed(depth_reg) < $signed(rd_data_reg.depth)) ||
                         ((depth_reg == rd_data_reg.depth) &&
                          ($signed(layer_reg) < $signed(rd_data_reg.layer)));

    assign new_entry = '{depth: depth_reg, layer: layer_reg, offset: offset, kind: kind_reg};

    assign stat.is_push  = (cmd_reg == CMD_PUSH);
    assign stat.is_read  = (cmd_reg == CMD_READ);
    assign stat.is_clear = (cmd_reg == CMD_CLEAR);
    assign stat.push_ok  = (need <= NEED_W'(capacity_reg)) &&
                           (count_reg < CNT_W'(MAX_ENTRIES));
    assign stat.read_ok  = (32'(rpos_reg) < 32'(count_reg));
    assign stat.scan_go  = (pos_reg != '0) && sorts_first;
    assign stat.count    = count_reg;

    always_comb begin
        if (cmd.start_push) begin
            rd_addr = POS_W'(count_reg - CNT_W'(1));
        end else if (cmd.read_issue) begin
            rd_addr = POS_W'(rpos_reg);
        end else begin
            rd_addr = POS_W'(pos_reg - CNT_W'(2));
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (cmd.scan_shift) begin
            mem[POS_W'(pos_reg)] <= rd_data_reg;
        end else if (cmd.scan_place) begin
            mem[POS_W'(pos_reg)] <= new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_push) begin
            pos_reg <= count_reg;
        end else if (cmd.scan_shift) begin
            pos_reg <= pos_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= 16'hFFFF;
            bytes_used_reg <= '0;
            count_reg      <= '0;
        end else begin
            if (cfg_wen) begin
                capacity_reg <= cfg_wdata;
            end
            if (cmd.scan_place) begin
                bytes_used_reg <= need[15:0];
                count_reg      <= count_reg + CNT_W'(1);
            end else if (cmd.do_clear) begin
                bytes_used_reg <= '0;
                count_reg      <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_place) begin
            res_acc_reg    <= 1'b1;
            res_poff_reg   <= offset;
            res_land_reg   <= 6'(pos_reg);
            res_rkind_reg  <= '0;
            res_roff_reg   <= '0;
            res_rdepth_reg <= '0;
            res_rlayer_reg <= '0;
            res_total_reg  <= 7'(count_reg + CNT_W'(1));
        end else if (cmd.read_done) begin
            res_acc_reg    <= 1'b1;
            res_poff_reg   <= '0;
            res_land_reg   <= '0;
            res_rkind_reg  <= rd_data_reg.kind;
            res_roff_reg   <= rd_data_reg.offset;
            res_rdepth_reg <= rd_data_reg.depth;
            res_rlayer_reg <= rd_data_reg.layer;
            res_total_reg  <= 7'(count_reg);
        end else if (cmd.res_none || cmd.do_clear) begin
            res_acc_reg    <= 1'b0;
            res_poff_reg   <= '0;
            res_land_reg   <= '0;
            res_rkind_reg  <= '0;
            res_roff_reg   <= '0;
            res_rdepth_reg <= '0;
            res_rlayer_reg <= '0;
            res_total_reg  <= cmd.do_clear ? 7'd0 : 7'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {3'b000, res_total_reg, res_rlayer_reg, res_rdepth_reg,
                            res_roff_reg, res_land_reg, res_poff_reg};
            m_tuser_reg <= {res_rkind_reg, res_acc_reg};
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ===== design/dsci_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences decode, insertion scan, read and output hand-off.
// Depends on dsci_pkg; drives dsci_datapath.
module dsci_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  dsci_pkg::dsci_stat_t stat,
    output dsci_pkg::dsci_cmd_t  cmd
);
    import dsci_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECIDE = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_RDATA  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.is_push && stat.push_ok) begin
                    cmd.start_push = 1'b1;
                    state_next     = ST_SCAN;
                end else if (stat.is_read && stat.read_ok) begin
                    cmd.read_issue = 1'b1;
                    state_next     = ST_RDATA;
                end else if (stat.is_clear) begin
                    cmd.do_clear = 1'b1;
                    state_next   = ST_FINISH;
                end else begin
                    cmd.res_none = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (stat.scan_go) begin
                    cmd.scan_shift = 1'b1;
                end else begin
                    cmd.scan_place = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_RDATA: begin
                cmd.read_done = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== design/depth_sorted_command_insert_core.sv =====
`timescale 1ns / 1ps
// Top level of the depth sorted command insert core.
// Depends on dsci_pkg, dsci_ctrl and dsci_datapath.

// Keeps up to 64 draw entries sorted by signed Q16.16 depth, then signed layer, with equal
// keys in arrival order. Each input item is a push, a read, a clear or an unused command, and
// yields exactly one result item. A push reserves 16 header bytes plus its payload in a buffer
// of cfg_wdata bytes (reset 65535); it is rejected when the buffer or the list is full. Entries
// live in a single-port-read, single-port-write memory, and a push walks it from the tail one
// entry per cycle, moving each held entry that sorts after the new one up a slot. Reads,
// clears, rejected pushes and unused commands skip the walk. One item is in work at a time;
// the next item is taken while a finished result still waits on the output register. Stored
// entries are not cleared at reset; reads only reach positions that a push has written.
module depth_sorted_command_insert_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config: buffer capacity in bytes
    input  logic                           cfg_wen,
    input  logic [15:0]                    cfg_wdata,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [11:0] payload_bytes, [43:12] depth_key, [59:44] layer, [65:60] read_position, pad
    input  logic [dsci_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] command, [3:2] entry_kind
    input  logic [dsci_pkg::S_TUSER_W-1:0] s_tuser,
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] payload_offset, [21:16] landed_position, [37:22] read_offset,
    // [69:38] read_depth, [85:70] read_layer, [92:86] entry_total, pad
    output logic [dsci_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] accepted, [2:1] read_kind
    output logic [dsci_pkg::M_TUSER_W-1:0] m_tuser
);
    import dsci_pkg::*;

    dsci_cmd_t  ctrl_cmd;
    dsci_stat_t dp_stat;

    dsci_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    dsci_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (ctrl_cmd),
        .stat      (dp_stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    // list never grows past its entry limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_stat.count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds list size");

    // only one item in work: intake closes right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");

    // a new result appears only from the output load
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(ctrl_cmd.load_out))
        else $error("result valid without output load");

    // insertion only ever runs on an accepted push
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_cmd.scan_shift || ctrl_cmd.scan_place) |-> dp_stat.is_push)
        else $error("insertion scan on a non-push item");
`endif

endmodule

// ===== tb/dsci_list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the depth sorted command insert core: watches both item channels and the
// capacity write port, predicts each result and compares it. Depends on dsci_pkg.
module dsci_list_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [15:0]                    cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [dsci_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [dsci_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [dsci_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [dsci_pkg::M_TUSER_W-1:0] m_tuser,
    output int                             fail_count,
    output int                             results_pending
);
    import dsci_pkg::*;

    typedef struct packed {
        logic               accepted;
        logic [1:0]         read_kind;
        logic [15:0]        payload_offset;
        logic [5:0]         landed_position;
        logic [15:0]        read_offset;
        logic signed [31:0] read_depth;
        logic signed [15:0] read_layer;
        logic [6:0]         entry_total;
    } list_result_t;

    // Shadow of the sorted list.
    logic signed [31:0] shadow_depth  [MAX_ENTRIES];
    logic signed [15:0] shadow_layer  [MAX_ENTRIES];
    logic [15:0]        shadow_offset [MAX_ENTRIES];
    logic [1:0]         shadow_kind   [MAX_ENTRIES];
    int                 shadow_held;
    int                 shadow_bytes;
    logic [15:0]        shadow_capacity;

    list_result_t expected_results[$];

    task automatic report_mismatch(input string msg);
        if (fail_count < 40)
            $display("%0t ns: MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    // Applies one item to the shadow list and returns the result it should give.
    function automatic list_result_t predict_list_result(
        input logic [1:0]         cmd,
        input logic [11:0]        payload,
        input logic [1:0]         kind,
        input logic signed [31:0] depth,
        input logic signed [15:0] layer,
        input logic [5:0]         rpos
    );
        list_result_t r;
        int           need;
        int           pos;
        r    = '0;
        need = shadow_bytes + HEADER_BYTES + int'(payload);
        case (cmd)
            CMD_PUSH: begin
                if (need <= int'(shadow_capacity) && shadow_held < MAX_ENTRIES) begin
                    pos = shadow_held;
                    // walk down from the tail; equal keys stay in arrival order
                    while (pos > 0 && (depth < shadow_depth[pos-1] ||
                           (depth == shadow_depth[pos-1] && layer < shadow_layer[pos-1]))) begin
                        shadow_depth[pos]  = shadow_depth[pos-1];
                        shadow_layer[pos]  = shadow_layer[pos-1];
                        shadow_offset[pos] = shadow_offset[pos-1];
                        shadow_kind[pos]   = shadow_kind[pos-1];
                        pos--;
                    end
                    shadow_depth[pos]  = depth;
                    shadow_layer[pos]  = layer;
                    shadow_offset[pos] = 16'(shadow_bytes + HEADER_BYTES);
                    shadow_kind[pos]   = kind;
                    r.accepted         = 1'b1;
                    r.payload_offset   = 16'(shadow_bytes + HEADER_BYTES);
                    r.landed_position  = 6'(pos);
                    shadow_held++;
                    shadow_bytes = need;
                end
            end
            CMD_READ: begin
                if (int'(rpos) < shadow_held) begin
                    r.accepted    = 1'b1;
                    r.read_kind   = shadow_kind[rpos];
                    r.read_offset = shadow_offset[rpos];
                    r.read_depth  = shadow_depth[rpos];
                    r.read_layer  = shadow_layer[rpos];
                end
            end
            CMD_CLEAR: begin
                shadow_held  = 0;
                shadow_bytes = 0;
            end
            default: ;
        endcase
        r.entry_total = 7'(shadow_held);
        return r;
    endfunction

    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (!aresetn) begin
            shadow_held     = 0;
            shadow_bytes    = 0;
            shadow_capacity = 16'hFFFF;
            fail_count      = 0;
            expected_results.delete();
        end else begin
            if (cfg_wen)
                shadow_capacity = cfg_wdata;
            // a result always belongs to an earlier item, so retire it first
            if (m_tvalid && m_tready) begin
                got.accepted        = m_tuser[0];
                got.read_kind       = m_tuser[2:1];
                got.payload_offset  = m_tdata[15:0];
                got.landed_position = m_tdata[21:16];
                got.read_offset     = m_tdata[37:22];
                got.read_depth      = m_tdata[69:38];
                got.read_layer      = m_tdata[85:70];
                got.entry_total     = m_tdata[92:86];
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch($sformatf("accepted got %0h want %0h",
                            got.accepted, want.accepted));
                    if (got.payload_offset !== want.payload_offset)
                        report_mismatch($sformatf("payload_offset got %0h want %0h",
                            got.payload_offset, want.payload_offset));
                    if (got.landed_position !== want.landed_position)
                        report_mismatch($sformatf("landed_position got %0d want %0d",
                            got.landed_position, want.landed_position));
                    if (got.read_kind !== want.read_kind)
                        report_mismatch($sformatf("read_kind got %0d want %0d",
                            got.read_kind, want.read_kind));
                    if (got.read_offset !== want.read_offset)
                        report_mismatch($sformatf("read_offset got %0h want %0h",
                            got.read_offset, want.read_offset));
                    if (got.read_depth !== want.read_depth)
                        report_mismatch($sformatf("read_depth got %0h want %0h",
                            got.read_depth, want.read_depth));
                    if (got.read_layer !== want.read_layer)
                        report_mismatch($sformatf("read_layer got %0h want %0h",
                            got.read_layer, want.read_layer));
                    if (got.entry_total !== want.entry_total)
                        report_mismatch($sformatf("entry_total got %0d want %0d",
                            got.entry_total, want.entry_total));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_list_result(s_tuser[1:0], s_tdata[11:0],
                    s_tuser[3:2], s_tdata[43:12], s_tdata[59:44], s_tdata[65:60]));
        end
        results_pending = expected_results.size();
    end

endmodule

// ===== tb/tb_depth_sorted_command_insert_core.sv =====
`timescale 1ns / 1ps
// Top of the depth sorted command insert core testbench: clock, reset, stimulus and verdict.
// Depends on dsci_pkg, depth_sorted_command_insert_core and dsci_list_checker.
module tb_depth_sorted_command_insert_core;
    import dsci_pkg::*;

    // Command code with no meaning; the block answers it without touching the list.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Entry kinds.
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_BITMAP = 2'd1;
    localparam logic [1:0] KIND_RECT   = 2'd2;
    localparam logic [1:0] KIND_TEXT   = 2'd3;

    // Frame key styles.
    localparam int KEYS_TIED       = 0;
    localparam int KEYS_RANDOM     = 1;
    localparam int KEYS_ASCENDING  = 2;
    localparam int KEYS_DESCENDING = 3;

    // Cycles with no item moving on either side before the run is called hung. A push
    // walks past at most 63 held entries; random stalls add to that.
    localparam int HANG_LIMIT = 2000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [15:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int fail_count;
    int results_pending;
    int sent_items  = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0; // when set, neither side idles

    // Keys that collide often, so ties and the extremes show up in the sort.
    logic [31:0] tie_depths [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                    32'hFFFF_FFFF, 32'h0001_0000};
    logic [15:0] tie_layers [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};

    // Per phase: capacity written at its start (last one random), item count it runs up to.
    logic [15:0] phase_capacity [6] = '{16'hFFFF, 16'h0000, 16'd3000, 16'd700,
                                        16'hFFFF, 16'h0000};
    int          phase_goal     [6] = '{320, 380, 620, 870, 1120, 1320};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    depth_sorted_command_insert_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [11:0] payload, [43:12] depth, [59:44] layer, [65:60] rpos
        .s_tuser  (s_tuser),   // [1:0] command, [3:2] entry_kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // offset, landed pos, read offset/depth/layer, entry total
        .m_tuser  (m_tuser)    // [0] accepted, [2:1] read_kind
    );

    dsci_list_checker list_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .results_pending(results_pending)
    );

    // Result side backpressure: drops tready at random, with odds of 36 in 100, except in the calm phase.
    always @(negedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 36);
    end

    // Hang watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("depth_sorted_command_insert_core regression: fail");
                $finish;
            end
        end
    end

    // Drives one item; called and returns at a falling edge. Random gaps come first, so
    // tvalid gets at most one assignment per step and stays high between items without gaps.
    task automatic send_item(input logic [1:0] cmd, input logic [11:0] payload,
                             input logic [1:0] kind, input logic [31:0] depth,
                             input logic [15:0] layer, input logic [5:0] rpos);
        while (!calm && $urandom_range(0, 99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, rpos, layer, depth, payload};
        s_tuser  <= {kind, cmd};
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
        sent_items++;
    endtask

    // Capacity is only changed with the block drained.
    task automatic write_capacity(input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // One frame: a clear, then a burst of mostly pushes mixed with reads and some noise.
    // Long bursts run the list into its entry limit.
    task automatic run_frame(input int n_items, input int key_style);
        int          pushes;
        int          pick;
        logic [31:0] depth;
        logic [15:0] layer;
        logic [11:0] payload;
        pushes = 0;
        send_item(CMD_CLEAR, 12'($urandom), 2'($urandom), $urandom, 16'($urandom),
                  6'($urandom));
        for (int i = 0; i < n_items; i++) begin
            case (key_style)
                KEYS_TIED:       depth = tie_depths[$urandom_range(0, 4)];
                KEYS_ASCENDING:  depth = i * 32'h0001_0000 - 32'h0040_0000;
                KEYS_DESCENDING: depth = 32'h0040_0000 - i * 32'h0001_0000;
                default:         depth = $urandom;
            endcase
            layer   = $urandom_range(0, 1) ? tie_layers[$urandom_range(0, 4)]
                                           : 16'($urandom);
            // mostly small payloads so 64 entries fit; now and then the full range
            payload = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                  : 12'($urandom_range(0, 200));
            pick    = $urandom_range(0, 99);
            if (pick < 62) begin
                send_item(CMD_PUSH, payload, 2'($urandom), depth, layer, 6'($urandom));
                pushes++;
            end else if (pick < 85) begin
                // likely a held position
                send_item(CMD_READ, payload, 2'($urandom), depth, layer,
                          6'($urandom_range(0, (pushes > 64) ? 63 :
                                               (pushes > 0) ? pushes - 1 : 0)));
            end else if (pick < 93) begin
                send_item(CMD_READ, payload, 2'($urandom), depth, layer, 6'($urandom));
            end else if (pick < 98) begin
                send_item(CMD_UNUSED, payload, 2'($urandom), depth, layer, 6'($urandom));
            end else begin
                send_item(CMD_CLEAR, payload, 2'($urandom), depth, layer, 6'($urandom));
                pushes = 0;
            end
        end
    endtask

    initial begin
        int frames;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty list, ignored command, key extremes, ties, reads in and out of range.
        send_item(CMD_READ, 12'd0, KIND_CLEAR, 32'd0, 16'd0, 6'd0);
        send_item(CMD_UNUSED, 12'hFFF, KIND_TEXT, 32'hFFFF_FFFF, 16'hFFFF, 6'h3F);
        // clear-type entry at the most negative depth
        send_item(CMD_PUSH, 12'd0, KIND_CLEAR, 32'h8000_0000, 16'h0000, 6'd0);
        send_item(CMD_PUSH, 12'hFFF, KIND_TEXT, 32'h7FFF_FFFF, 16'h7FFF, 6'h3F);
        send_item(CMD_PUSH, 12'd100, KIND_BITMAP, 32'd0, 16'h8000, 6'd0);
        // same depth and layer: must land after the earlier one
        send_item(CMD_PUSH, 12'd5, KIND_RECT, 32'd0, 16'h8000, 6'd0);
        send_item(CMD_PUSH, 12'd7, KIND_BITMAP, 32'd0, 16'h0005, 6'd0);
        // lowest layer at the lowest depth goes to the head
        send_item(CMD_PUSH, 12'd0, KIND_CLEAR, 32'h8000_0000, 16'h8000, 6'd0);
        for (int p = 0; p < 8; p++)
            send_item(CMD_READ, 12'd0, KIND_CLEAR, 32'd0, 16'd0, 6'(p));
        send_item(CMD_READ, 12'd0, KIND_CLEAR, 32'd0, 16'd0, 6'd63);
        send_item(CMD_CLEAR, 12'd0, KIND_CLEAR, 32'd0, 16'd0, 6'd0);
        send_item(CMD_READ, 12'd0, KIND_CLEAR, 32'd0, 16'd0, 6'd0);
        // room for exactly one header, then none
        write_capacity(16'd16);
        send_item(CMD_PUSH, 12'd0, KIND_RECT, 32'h0001_0000, 16'd1, 6'd0);
        send_item(CMD_PUSH, 12'd0, KIND_RECT, 32'h0001_0000, 16'd1, 6'd0);
        // capacity dropped below the bytes already in use
        write_capacity(16'd8);
        send_item(CMD_PUSH, 12'd0, KIND_BITMAP, 32'd0, 16'd0, 6'd0);
        send_item(CMD_READ, 12'd0, KIND_CLEAR, 32'd0, 16'd0, 6'd0);

        // Random phases, one capacity each; the second full-size phase runs with no idling.
        frames = 0;
        for (int ph = 0; ph < 6; ph++) begin
            write_capacity(ph == 5 ? 16'($urandom) : phase_capacity[ph]);
            calm = (ph == 4);
            run_frame(140, KEYS_RANDOM);
            while (sent_items < phase_goal[ph]) begin
                run_frame($urandom_range(4, 140), $urandom_range(KEYS_TIED, KEYS_DESCENDING));
                frames++;
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (results_pending != 0)
            @(negedge aclk);
        repeat (80) @(negedge aclk);
        if (fail_count == 0)
            $display("depth_sorted_command_insert_core regression: pass");
        else
            $display("depth_sorted_command_insert_core regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dsci_pkg.sv
design/dsci_datapath.sv
design/dsci_ctrl.sv
design/depth_sorted_command_insert_core.sv
tb/dsci_list_checker.sv
tb/tb_depth_sorted_command_insert_core.sv
